// ===== rtl/core/pcie_ecam_address_translator_defines.svh =====
// ----------------------------------------------------------------------------
// PCIe ECAM address translator assertion macros
// Shared assertion wrappers clocked on clock, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef PCIE_ECAM_ADDRESS_TRANSLATOR_DEFINES_SVH
`define PCIE_ECAM_ADDRESS_TRANSLATOR_DEFINES_SVH

// Checked only outside reset.
`define PECAM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define PECAM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/pcie_ecam_pkg.sv =====
// ----------------------------------------------------------------------------
// PCIe ECAM translator package
// Payload types, register indexes, status codes and field constants.
// ----------------------------------------------------------------------------
package pcie_ecam_pkg;

   localparam int WINDOW_ENTRIES_DEFAULT = 4;
   localparam int SLOT_MASK_WIDTH = 32;
   localparam int SLOT_INDEX_WIDTH = $clog2(SLOT_MASK_WIDTH);
   localparam int CSR_WINDOW_REGS = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int COUNT_WIDTH = 3;
   localparam int ADDR_WIDTH = 32;
   localparam int BUS_SHIFT = 20;
   localparam int DEVFN_SHIFT = 12;
   localparam int OFFSET_WIDTH = 12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_COUNT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FALLBACK_MASK = 3'd5;

   typedef enum logic [1:0] {
      STATUS_MMIO      = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_FALLBACK  = 2'd2,
      STATUS_NO_ACCESS = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]            end_bus;
      logic [7:0]            start_bus;
      logic [15:0]           segment;
      logic [ADDR_WIDTH-1:0] base;
   } window_entry_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]     window_count;
      logic [SLOT_MASK_WIDTH-1:0] fallback_slot_mask;
   } csr_ctrl_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] segment;
      logic [8:0]  bus_number;
      logic [8:0]  device_function;
      logic [12:0] register_offset;
      logic [2:0]  access_length;
      logic [31:0] write_data;
   } req_payload_type;

   typedef struct packed {
      status_type            status;
      logic [ADDR_WIDTH-1:0] access_address;
      logic                  window_changed;
      logic                  is_write;
      logic [2:0]            access_size;
      logic [31:0]           data_out;
   } rsp_payload_type;

   typedef struct packed {
      logic                  update;
      logic [ADDR_WIDTH-1:0] window;
   } window_update_type;

endpackage

// ===== rtl/core/pcie_ecam_stream_if.sv =====
// ----------------------------------------------------------------------------
// PCIe ECAM stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface pcie_ecam_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pcie_ecam_csr.sv =====
// ----------------------------------------------------------------------------
// PCIe ECAM configuration registers
// Window table, window count and fallback slot mask, written by index.
// ----------------------------------------------------------------------------
module pcie_ecam_csr #(
   parameter int WINDOW_ENTRIES = pcie_ecam_pkg::WINDOW_ENTRIES_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_write_enable,
   input  logic [pcie_ecam_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pcie_ecam_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output pcie_ecam_pkg::window_entry_type             entries [WINDOW_ENTRIES],
   output pcie_ecam_pkg::csr_ctrl_type                 ctrl
);
   import pcie_ecam_pkg::*;

   localparam int WindowRegs =
      (WINDOW_ENTRIES < CSR_WINDOW_REGS) ? WINDOW_ENTRIES : CSR_WINDOW_REGS;

   csr_ctrl_type ctrl_ff;
   csr_ctrl_type ctrl_in;

   always_comb begin
      ctrl_in = ctrl_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_COUNT: begin
               ctrl_in.window_count = csr_write_data[COUNT_WIDTH-1:0];
            end
            CSR_FALLBACK_MASK: begin
               ctrl_in.fallback_slot_mask = csr_write_data[SLOT_MASK_WIDTH-1:0];
            end
            default: begin
               ctrl_in = ctrl_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

   for (genvar i = 0; i < WINDOW_ENTRIES; i++) begin : g_entry
      if (i < WindowRegs) begin : g_reg
         window_entry_type entry_ff;
         window_entry_type entry_in;

         always_comb begin
            entry_in = entry_ff;
            if (csr_write_enable && (csr_index == CSR_INDEX_WIDTH'(i))) begin
               entry_in = csr_write_data;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               entry_ff <= '0;
            end else begin
               entry_ff <= entry_in;
            end
         end

         assign entries[i] = entry_ff;
      end else begin : g_none
         assign entries[i] = '0;
      end
   end

endmodule

// ===== rtl/core/pcie_ecam_lookup.sv =====
// ----------------------------------------------------------------------------
// PCIe ECAM window lookup
// Range check, window selection and address formation for one request.
// ----------------------------------------------------------------------------
module pcie_ecam_lookup #(
   parameter int WINDOW_ENTRIES = pcie_ecam_pkg::WINDOW_ENTRIES_DEFAULT
) (
   input  pcie_ecam_pkg::req_payload_type                  req,
   input  pcie_ecam_pkg::window_entry_type                 entries [WINDOW_ENTRIES],
   input  pcie_ecam_pkg::csr_ctrl_type                     ctrl,
   input  logic [pcie_ecam_pkg::ADDR_WIDTH-1:0]            last_window,
   output pcie_ecam_pkg::rsp_payload_type                  rsp,
   output pcie_ecam_pkg::window_update_type                win_update
);
   import pcie_ecam_pkg::*;

   logic                             invalid;
   logic                             forced;
   logic                             lone;
   logic                             length_ok;
   logic [WINDOW_ENTRIES-1:0]        hit;
   logic                             table_hit;
   logic [ADDR_WIDTH-1:0]            table_base;
   logic [ADDR_WIDTH-1:0]            base;
   logic [ADDR_WIDTH-1:0]            window;
   logic [SLOT_INDEX_WIDTH-1:0]      slot;

   assign invalid = req.bus_number[8] | req.device_function[8] | req.register_offset[12];
   assign slot = req.device_function[3 +: SLOT_INDEX_WIDTH];
   assign forced = (req.segment == '0) && (req.bus_number == '0) &&
                   ctrl.fallback_slot_mask[slot];

   always_comb begin
      for (int i = 0; i < WINDOW_ENTRIES; i++) begin
         hit[i] = ({1'b0, ctrl.window_count} > 4'(i)) &&
                  (entries[i].segment == req.segment) &&
                  (entries[i].start_bus <= req.bus_number[7:0]) &&
                  (entries[i].end_bus >= req.bus_number[7:0]);
      end
   end

   always_comb begin
      table_hit = 1'b0;
      table_base = '0;
      for (int i = WINDOW_ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            table_hit = 1'b1;
            table_base = entries[i].base;
         end
      end
   end

   // A single table entry that covers only segment 0, bus 0 serves every bus.
   assign lone = ((WINDOW_ENTRIES == 1) ? (ctrl.window_count != '0)
                                        : (ctrl.window_count == COUNT_WIDTH'(1))) &&
                 (entries[0].segment == '0) &&
                 (entries[0].start_bus == '0) && (entries[0].end_bus == '0);

   always_comb begin
      if (forced) begin
         base = '0;
      end else if (table_hit) begin
         base = table_base;
      end else if (lone) begin
         base = entries[0].base;
      end else begin
         base = '0;
      end
   end

   assign window = base |
                   (ADDR_WIDTH'(req.bus_number[7:0]) << BUS_SHIFT) |
                   (ADDR_WIDTH'(req.device_function[7:0]) << DEVFN_SHIFT);

   assign length_ok = (req.access_length == 3'd1) || (req.access_length == 3'd2) ||
                      (req.access_length == 3'd4);

   always_comb begin
      rsp.access_address = '0;
      rsp.window_changed = 1'b0;
      rsp.is_write = req.opcode;
      rsp.access_size = req.access_length;
      rsp.data_out = req.opcode ? req.write_data : '0;
      win_update.update = 1'b0;
      win_update.window = window;
      if (invalid) begin
         rsp.status = STATUS_INVALID;
         rsp.data_out = '0;
      end else if (base == '0) begin
         rsp.status = STATUS_FALLBACK;
      end else begin
         win_update.update = 1'b1;
         rsp.window_changed = (window != last_window);
         if (length_ok) begin
            rsp.status = STATUS_MMIO;
            rsp.access_address = window +
                                 ADDR_WIDTH'(req.register_offset[OFFSET_WIDTH-1:0]);
         end else begin
            rsp.status = STATUS_NO_ACCESS;
         end
      end
   end

endmodule

// ===== rtl/core/pcie_ecam_address_translator.sv =====
// ----------------------------------------------------------------------------
// PCIe ECAM address translator
// Translates configuration-space requests into flat ECAM addresses.
//
//   Channel  Direction  Beat
//   req_chan in         one access request (opcode, target, offset, data)
//   rsp_chan out        one result (status, address, window change, copies)
//   csr_*    in         register write by index, no read-back
//
// One request per cycle is sustained while results are taken; each request
// passes through the input register and then the result register before its
// result beat is offered.
// While a result waits to be taken, the input register takes one more request
// and then holds ready low until the waiting result leaves.
// Reset is synchronous; it clears the configuration registers, the last window
// and both valid flags.
// ----------------------------------------------------------------------------
module pcie_ecam_address_translator #(
   parameter int WINDOW_ENTRIES = pcie_ecam_pkg::WINDOW_ENTRIES_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   pcie_ecam_stream_if.sink                          req_chan,
   pcie_ecam_stream_if.source                        rsp_chan,
   input  logic                                      csr_write_enable,
   input  logic [pcie_ecam_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pcie_ecam_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import pcie_ecam_pkg::*;

   window_entry_type      entries [WINDOW_ENTRIES];
   csr_ctrl_type          ctrl;
   rsp_payload_type       result;
   window_update_type     win_update;

   logic                  stage_valid_ff;
   logic                  stage_valid_in;
   req_payload_type       stage_payload_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_payload_type       rsp_payload_ff;
   logic [ADDR_WIDTH-1:0] last_window_ff;
   logic                  advance;
   logic                  req_beat;

   pcie_ecam_csr #(
      .WINDOW_ENTRIES(WINDOW_ENTRIES)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .entries         (entries),
      .ctrl            (ctrl)
   );

   pcie_ecam_lookup #(
      .WINDOW_ENTRIES(WINDOW_ENTRIES)
   ) u_lookup (
      .req        (stage_payload_ff),
      .entries    (entries),
      .ctrl       (ctrl),
      .last_window(last_window_ff),
      .rsp        (result),
      .win_update (win_update)
   );

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_beat = req_chan.valid && req_chan.ready;

   assign stage_valid_in = req_beat || (stage_valid_ff && !advance);
   assign rsp_valid_in = advance ? stage_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_window_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && stage_valid_ff && win_update.update) begin
            last_window_ff <= win_update.window;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         stage_payload_ff <= req_chan.payload;
      end
      if (advance && stage_valid_ff) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

// ===== rtl/core/pcie_ecam_checker.sv =====
// ----------------------------------------------------------------------------
// PCIe ECAM translator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pcie_ecam_address_translator_defines.svh"

module pcie_ecam_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input pcie_ecam_pkg::rsp_payload_type rsp_payload
);
   import pcie_ecam_pkg::*;

   `PECAM_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

   `PECAM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled result beat changed")

   `PECAM_ASSERT(a_no_window_change, rsp_valid && (rsp_payload.status == STATUS_INVALID || rsp_payload.status == STATUS_FALLBACK) |-> !rsp_payload.window_changed, "window change flagged without a window")

   `PECAM_ASSERT(a_address_zero, rsp_valid && rsp_payload.status != STATUS_MMIO |-> rsp_payload.access_address == '0, "address given without a mapped access")

endmodule

bind pcie_ecam_address_translator pcie_ecam_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);
